[sv/itp_pkg.sv]
// itp_pkg: shared types, character codes and precedence tables of the
// infix to postfix converter. No dependencies.
`default_nettype none

package itp_pkg;

   // default number of operator stack entries
   localparam int STACK_DEPTH_DEF = 32;

   localparam int SYM_W = 8;
   localparam int ERR_W = 2;
   localparam int PREC_W = 3;

   // error codes of a result word
   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

   // character codes
   localparam logic [SYM_W-1:0] CH_OPEN    = 8'h28;
   localparam logic [SYM_W-1:0] CH_CLOSE   = 8'h29;
   localparam logic [SYM_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [SYM_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [SYM_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [SYM_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [SYM_W-1:0] CH_CARET   = 8'h5E;
   localparam logic [SYM_W-1:0] CH_UPPER_A = 8'd65;
   localparam logic [SYM_W-1:0] CH_UPPER_Z = 8'd90;
   localparam logic [SYM_W-1:0] CH_LOWER_A = 8'd97;
   localparam logic [SYM_W-1:0] CH_LOWER_Z = 8'd122;
   localparam logic [SYM_W-1:0] SYM_ZERO   = 8'd0;

   typedef enum logic [2:0] {
      K_LETTER,
      K_OPEN,
      K_CLOSE,
      K_OPER,
      K_OTHER
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PUSH,
      ST_ERR,
      ST_FINISH
   } state_type;

   // decision on the current stack top
   typedef struct packed {
      logic pop;
      logic emit;
      logic matched;
   } judge_type;

   // in-stack precedence, zero for an open paren
   function automatic logic [PREC_W-1:0] prec_in(input logic [SYM_W-1:0] c);
      logic [PREC_W-1:0] p;
      unique case (c)
         CH_PLUS, CH_MINUS: p = 3'd2;
         CH_STAR, CH_SLASH: p = 3'd4;
         CH_CARET:          p = 3'd5;
         default:           p = 3'd0;
      endcase
      return p;
   endfunction

   // incoming precedence, zero when not an operator
   function automatic logic [PREC_W-1:0] prec_inc(input logic [SYM_W-1:0] c);
      logic [PREC_W-1:0] p;
      unique case (c)
         CH_PLUS, CH_MINUS: p = 3'd1;
         CH_STAR, CH_SLASH: p = 3'd3;
         CH_CARET:          p = 3'd6;
         default:           p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic kind_type classify(input logic [SYM_W-1:0] c);
      kind_type k;
      priority if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                   (c >= CH_LOWER_A && c <= CH_LOWER_Z)) k = K_LETTER;
      else if (c == CH_OPEN)                           k = K_OPEN;
      else if (c == CH_CLOSE)                          k = K_CLOSE;
      else if (prec_inc(c) != 3'd0)                    k = K_OPER;
      else                                             k = K_OTHER;
      return k;
   endfunction

endpackage

`default_nettype wire

[sv/itp_ram.sv]
// itp_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`default_nettype none

module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/itp_judge.sv]
// itp_judge: compare unit that decides, for one stack top, whether to pop
// it and whether to emit it. Depends on itp_pkg.
`default_nettype none

module itp_judge (
   input  wire logic                       is_end,
   input  wire logic [itp_pkg::SYM_W-1:0]  cur_ch,
   input  wire logic [itp_pkg::SYM_W-1:0]  top_ch,
   output itp_pkg::judge_type              judge
);

   logic top_open;
   logic cur_close;

   assign top_open  = (top_ch == itp_pkg::CH_OPEN);
   assign cur_close = (itp_pkg::classify(cur_ch) == itp_pkg::K_CLOSE);

   // end flushes, close walks to its paren, operator compares precedence
   always_comb begin
      judge = '0;
      priority if (is_end) begin
         judge.pop  = 1'b1;
         judge.emit = !top_open;
      end else if (cur_close) begin
         judge.pop     = 1'b1;
         judge.emit    = !top_open;
         judge.matched = top_open;
      end else begin
         judge.pop  = (itp_pkg::prec_in(top_ch) >= itp_pkg::prec_inc(cur_ch));
         judge.emit = judge.pop;
      end
   end

endmodule

`default_nettype wire

[sv/infix_to_postfix_converter.sv]
// infix_to_postfix_converter: top level, sequencer, operator stack and
// result registers. Depends on itp_pkg, itp_ram and itp_judge.
`default_nettype none

// Shunting-yard converter. Each input word is one infix character
// (req_tuser low) or an end mark (req_tuser high); result words carry
// postfix characters, with tlast on the final word caused by an input
// word and a nonzero error code on an overflow or unmatched ')' word.
// The block takes one input word at a time and deasserts req_tready
// while it works on it. A letter is emitted directly, a '(' is pushed
// and an ignored character is dropped. An operator pops the stack top
// by precedence before it is pushed; a ')' pops to its '(' or raises an
// unmatched error; an end mark flushes the stack. Each entry examined
// takes a read state and an evaluate state, since the operator stack is
// one RAM with a single registered read port walked from the top. A
// result waits in one pending register and one output register, so a
// slow consumer stalls the walk but does not lose words. Stack contents
// are not cleared at reset and need no clearing pass; of the stack,
// only the fill count resets.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // [7:0] ch
   input  wire logic                       req_tuser,   // [0] op (end mark)
   // result channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] sym
   output logic                            rsp_tlast,   // last
   output logic [1:0]                      rsp_tuser    // [1:0] error
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   itp_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                count_ff, count_in;
   logic                         cur_op_ff, cur_op_in;
   logic [itp_pkg::SYM_W-1:0]    cur_ch_ff, cur_ch_in;

   logic                         pend_valid_ff;
   logic [itp_pkg::SYM_W-1:0]    pend_sym_ff;
   logic [itp_pkg::ERR_W-1:0]    pend_err_ff;

   logic                         out_valid_ff;
   logic [itp_pkg::SYM_W-1:0]    out_sym_ff;
   logic                         out_last_ff;
   logic [itp_pkg::ERR_W-1:0]    out_err_ff;

   logic                         produce;
   logic [itp_pkg::SYM_W-1:0]    res_sym;
   logic [itp_pkg::ERR_W-1:0]    res_err;
   logic                         move_out;
   logic                         move_last;

   logic                         out_free;
   logic                         prod_ok;
   logic                         full;
   logic                         cnt_one;
   logic                         cnt_zero;

   logic                         wr_en;
   logic                         rd_en;
   logic [AW-1:0]                top_addr;
   logic [itp_pkg::SYM_W-1:0]    top_ch;
   itp_pkg::judge_type           judge;
   itp_pkg::kind_type            in_kind;
   itp_pkg::kind_type            cur_kind;

   assign out_free = !out_valid_ff || rsp_tready;
   assign prod_ok  = !pend_valid_ff || out_free;
   assign full     = (count_ff >= CW'(STACK_DEPTH));
   assign cnt_one  = (count_ff == CW'(1));
   assign cnt_zero = (count_ff == '0);
   assign in_kind  = itp_pkg::classify(req_tdata);
   assign cur_kind = itp_pkg::classify(cur_ch_ff);

   // top entry address, count minus one
   logic [CW-1:0] count_dec;
   assign count_dec = count_ff - CW'(1);
   assign top_addr  = count_dec[AW-1:0];

   // operator stack
   itp_ram #(
      .WIDTH (itp_pkg::SYM_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cur_ch_ff),
      .rd_en   (rd_en),
      .rd_addr (top_addr),
      .rd_data (top_ch)
   );

   // precedence compare on the stack top
   itp_judge u_judge (
      .is_end (cur_op_ff),
      .cur_ch (cur_ch_ff),
      .top_ch (top_ch),
      .judge  (judge)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itp_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (produce) begin
            pend_valid_ff <= 1'b1;
         end else if (move_out) begin
            pend_valid_ff <= 1'b0;
         end
         if (move_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_op_ff <= cur_op_in;
      cur_ch_ff <= cur_ch_in;
      if (produce) begin
         pend_sym_ff <= res_sym;
         pend_err_ff <= res_err;
      end
      if (move_out) begin
         out_sym_ff  <= pend_sym_ff;
         out_err_ff  <= pend_err_ff;
         out_last_ff <= move_last;
      end
   end

   // sequencer: next state, stack access and result hand-off
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cur_op_in  = cur_op_ff;
      cur_ch_in  = cur_ch_ff;
      req_tready = 1'b0;
      produce    = 1'b0;
      res_sym    = itp_pkg::SYM_ZERO;
      res_err    = itp_pkg::ERR_NONE;
      move_out   = 1'b0;
      move_last  = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      unique case (state_ff)
         itp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cur_op_in = req_tuser;
               cur_ch_in = req_tdata;
               if (req_tuser) begin
                  state_in = cnt_zero ? itp_pkg::ST_IDLE : itp_pkg::ST_READ;
               end else begin
                  unique case (in_kind)
                     itp_pkg::K_LETTER: begin
                        produce  = 1'b1;
                        res_sym  = req_tdata;
                        state_in = itp_pkg::ST_FINISH;
                     end
                     itp_pkg::K_OPEN:  state_in = itp_pkg::ST_PUSH;
                     itp_pkg::K_CLOSE: begin
                        state_in = cnt_zero ? itp_pkg::ST_ERR : itp_pkg::ST_READ;
                     end
                     itp_pkg::K_OPER: begin
                        state_in = cnt_zero ? itp_pkg::ST_PUSH : itp_pkg::ST_READ;
                     end
                     default: state_in = itp_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         itp_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = itp_pkg::ST_EVAL;
         end
         itp_pkg::ST_EVAL: begin
            if (!judge.emit || prod_ok) begin
               if (judge.emit) begin
                  produce  = 1'b1;
                  res_sym  = top_ch;
                  move_out = pend_valid_ff;
               end
               if (judge.pop) begin
                  count_in = count_dec;
               end
               priority if (!judge.pop) begin
                  state_in = itp_pkg::ST_PUSH;
               end else if (judge.matched) begin
                  state_in = itp_pkg::ST_FINISH;
               end else if (cnt_one) begin
                  priority if (cur_op_ff)            state_in = itp_pkg::ST_FINISH;
                  else if (cur_kind == itp_pkg::K_CLOSE) state_in = itp_pkg::ST_ERR;
                  else                               state_in = itp_pkg::ST_PUSH;
               end else begin
                  state_in = itp_pkg::ST_READ;
               end
            end
         end
         itp_pkg::ST_PUSH: begin
            if (full) begin
               if (prod_ok) begin
                  produce  = 1'b1;
                  res_err  = itp_pkg::ERR_OVERFLOW;
                  move_out = pend_valid_ff;
                  state_in = itp_pkg::ST_FINISH;
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = itp_pkg::ST_FINISH;
            end
         end
         itp_pkg::ST_ERR: begin
            if (prod_ok) begin
               produce  = 1'b1;
               res_err  = itp_pkg::ERR_UNMATCHED;
               move_out = pend_valid_ff;
               state_in = itp_pkg::ST_FINISH;
            end
         end
         itp_pkg::ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = itp_pkg::ST_IDLE;
            end else if (out_free) begin
               move_out  = 1'b1;
               move_last = 1'b1;
               state_in  = itp_pkg::ST_IDLE;
            end
         end
         default: state_in = itp_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // fill count stays within the stack
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // a new word is taken only with no result held back
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("input accepted with a pending result");

   // an error word carries no symbol and closes its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != itp_pkg::ERR_NONE) |->
         (rsp_tdata == itp_pkg::SYM_ZERO && rsp_tlast))
      else $error("error word malformed");

   // the stack top is evaluated only after a read was issued
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == itp_pkg::ST_EVAL) |->
         ($past(state_ff) == itp_pkg::ST_READ || $past(state_ff) == itp_pkg::ST_EVAL))
      else $error("stack top used without read");

   // a pop never happens on an empty stack
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == itp_pkg::ST_EVAL) |-> !cnt_zero)
      else $error("evaluation with empty stack");

endmodule

`default_nettype wire
